[hdl/b64d_pkg.sv]
// Shared types and codes of the base64 stream decoder.
// No dependencies; the front end, queue, sequencer and top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

   // result kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // final status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_COUNT    = 2'd2;
   localparam logic [1:0] STATUS_PAD      = 2'd3;

   // pad character
   localparam logic [7:0] CHAR_PAD = 8'h3D;

   // work passed from the front end to the result sequencer
   typedef struct packed {
      logic [1:0]      byte_count;
      logic [2:0][7:0] bytes;
      logic            has_status;
      logic [1:0]      status;
   } job_type;

endpackage

`default_nettype wire

[hdl/b64d_if.sv]
// Valid/ready channel interfaces for the decoder's character input and result output.
// Depends on nothing; the top level takes these as its channel ports.
`timescale 1ns / 1ps
`default_nettype none

interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] data_byte;
   logic [1:0] status;
   logic       last_result;

   modport source (output valid, output result_kind, output data_byte,
                   output status, output last_result, input ready);
   modport sink   (input valid, input result_kind, input data_byte,
                   input status, input last_result, output ready);
endinterface

`default_nettype wire

[hdl/b64d_front.sv]
// Front end: classifies characters, assembles groups of four symbols and builds jobs.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [7:0]       char_code,
   input  wire logic             last_char,
   input  wire logic             queue_full,
   output logic                  push,
   output b64d_pkg::job_type     push_job
);
   import b64d_pkg::*;

   // map a character to its 6-bit symbol value; bit 6 flags a valid symbol
   function automatic logic [6:0] decode_char(input logic [7:0] ch);
      logic [7:0] v;
      v = 8'd0;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         v = ch - 8'd65;
         return {1'b1, v[5:0]};
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         v = ch - 8'd71;
         return {1'b1, v[5:0]};
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         v = ch + 8'd4;
         return {1'b1, v[5:0]};
      end else if (ch == 8'h2B) begin
         return {1'b1, 6'd62};
      end else if (ch == 8'h2F) begin
         return {1'b1, 6'd63};
      end else if (ch == CHAR_PAD) begin
         return {1'b1, 6'd0};
      end
      return 7'd0;
   endfunction

   logic [2:0][5:0] symbols_ff, symbols_in;
   logic [1:0]      position_ff, position_in;
   logic [2:0]      pads_ff, pads_in;
   logic [1:0]      count_ff, count_in;
   logic            seen_ff, seen_in;
   logic            stopped_ff, stopped_in;
   logic            pad_err_ff, pad_err_in;

   logic [6:0] decoded;
   logic       is_valid;
   logic       is_pad;
   logic [5:0] sym;
   logic [2:0] pads_sum;
   logic       accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign decoded  = decode_char(char_code);
   assign is_valid = decoded[6];
   assign sym      = decoded[5:0];
   assign is_pad   = (char_code == CHAR_PAD);
   assign pads_sum = pads_ff + {2'b00, is_pad};

   // next state and job for the incoming character
   always_comb begin
      symbols_in = symbols_ff;
      position_in = position_ff;
      pads_in = pads_ff;
      count_in = count_ff;
      seen_in = seen_ff;
      stopped_in = stopped_ff;
      pad_err_in = pad_err_ff;
      push_job = '0;
      push = 1'b0;

      if (is_valid) begin
         seen_in = 1'b1;
         count_in = count_ff + 2'd1;
         if (!stopped_ff) begin
            pads_in = pads_sum;
            position_in = position_ff + 2'd1;
            if (position_ff != 2'd3) begin
               symbols_in[position_ff] = sym;
            end else begin
               // group complete: form three bytes, trim by pad count
               push_job.bytes[0] = {symbols_ff[0], symbols_ff[1][5:4]};
               push_job.bytes[1] = {symbols_ff[1][3:0], symbols_ff[2][5:2]};
               push_job.bytes[2] = {symbols_ff[2][1:0], sym};
               if (pads_sum > 3'd2) begin
                  push_job.byte_count = 2'd0;
                  pad_err_in = 1'b1;
               end else begin
                  push_job.byte_count = 2'd3 - pads_sum[1:0];
               end
               if (pads_sum != 3'd0) begin
                  stopped_in = 1'b1;
               end
               pads_in = 3'd0;
            end
         end
      end

      // status on the final character, then clear the group state
      if (last_char) begin
         push_job.has_status = 1'b1;
         if (!seen_in) begin
            push_job.status = STATUS_EMPTY;
         end else if (count_in != 2'd0) begin
            push_job.status = STATUS_COUNT;
         end else if (pad_err_in) begin
            push_job.status = STATUS_PAD;
         end else begin
            push_job.status = STATUS_OK;
         end
         position_in = 2'd0;
         pads_in = 3'd0;
         count_in = 2'd0;
         seen_in = 1'b0;
         stopped_in = 1'b0;
         pad_err_in = 1'b0;
      end

      push = accept && (push_job.byte_count != 2'd0 || push_job.has_status);
   end

   // symbol slots hold payload only
   always_ff @(posedge clock) begin
      if (accept) begin
         symbols_ff <= symbols_in;
      end
   end

   // advance group state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 2'd0;
         pads_ff <= 3'd0;
         count_ff <= 2'd0;
         seen_ff <= 1'b0;
         stopped_ff <= 1'b0;
         pad_err_ff <= 1'b0;
      end else if (accept) begin
         position_ff <= position_in;
         pads_ff <= pads_in;
         count_ff <= count_in;
         seen_ff <= seen_in;
         stopped_ff <= stopped_in;
         pad_err_ff <= pad_err_in;
      end
   end

endmodule

`default_nettype wire

[hdl/b64d_queue.sv]
// Two-entry job queue between the front end and the result sequencer.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire b64d_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output b64d_pkg::job_type      pop_job,
   output logic                   empty
);
   import b64d_pkg::*;

   localparam int Depth = 2;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   job_type             entries_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign pop_job = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // store a job on each push
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[hdl/b64d_back.sv]
// Result sequencer: plays out each job as data bytes then an optional status, one per transfer.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire b64d_pkg::job_type pop_job,
   input  wire logic              empty,
   output logic                   pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic                   result_kind,
   output logic [7:0]             data_byte,
   output logic [1:0]             status,
   output logic                   last_result
);
   import b64d_pkg::*;

   job_type    job_ff, job_in;
   logic       busy_ff, busy_in;
   logic [1:0] index_ff, index_in;

   logic in_bytes;
   logic fire;
   logic load;

   // select the current result of the held job
   assign in_bytes    = (index_ff < job_ff.byte_count);
   assign result_kind = in_bytes ? KIND_DATA : KIND_STATUS;
   assign data_byte   = in_bytes ? job_ff.bytes[index_ff] : 8'd0;
   assign status      = in_bytes ? STATUS_OK : job_ff.status;
   assign last_result = in_bytes ?
                        ((index_ff == job_ff.byte_count - 2'd1) && !job_ff.has_status) : 1'b1;
   assign out_valid   = busy_ff;

   assign fire = busy_ff && out_ready;
   assign load = !busy_ff || (fire && last_result);
   assign pop  = load && !empty;

   // load the next job or advance within the current one
   always_comb begin
      job_in = job_ff;
      busy_in = busy_ff;
      index_in = index_ff;
      if (load) begin
         busy_in = !empty;
         job_in = pop_job;
         index_in = 2'd0;
      end else if (fire) begin
         index_in = index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         index_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         index_ff <= index_in;
      end
   end

endmodule

`default_nettype wire

[hdl/base64_stream_decoder_top.sv]
// Top level of the base64 stream decoder: front end, job queue and result sequencer.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_queue and b64d_back.
//
//   channel   dir  handshake           payload
//   req_chan  in   valid/ready         char_code[7:0], last_char
//   rsp_chan  out  valid/ready         result_kind, data_byte[7:0], status[1:0], last_result
//
// One character is taken per cycle while the two-entry job queue has room.
// The sequencer emits one result per cycle while the output is ready, so a character that
// completes a group gives up to three data bytes, followed by a status on the last character.
// Characters that cause no result never enter the queue.
// Reset is synchronous and clears the group state and the queue's pointers and fill count.
// A stalled output fills the queue, after which input is held off.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder_top (
   input  wire logic   clock,
   input  wire logic   reset,
   b64d_req_if.sink    req_chan,
   b64d_rsp_if.source  rsp_chan
);
   import b64d_pkg::*;

   job_type push_job;
   job_type pop_job;
   logic    push;
   logic    pop;
   logic    full;
   logic    empty;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .char_code  (req_chan.char_code),
      .last_char  (req_chan.last_char),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   b64d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_job     (pop_job),
      .empty       (empty),
      .pop         (pop),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .result_kind (rsp_chan.result_kind),
      .data_byte   (rsp_chan.data_byte),
      .status      (rsp_chan.status),
      .last_result (rsp_chan.last_result)
   );

endmodule

`default_nettype wire
